/* src/circular_array_sequence_macros.svh */
// Assertion macros for the circular array sequence block.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef CIRCULAR_ARRAY_SEQUENCE_MACROS_SVH
`define CIRCULAR_ARRAY_SEQUENCE_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CAS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define CAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAS_ASSERT(label, ante, cons, msg)
`define CAS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/cas_pkg.sv */
package cas_pkg;

  // Capacity of the list and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the transactions.
  localparam int WORD_W = 32;
  localparam int OP_W   = 4;
  localparam int POS_W  = 4;
  localparam int ST_W   = 2;
  localparam int CNTF_W = 5;

  // Command codes.
  localparam logic [OP_W-1:0] OP_INSERT      = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT   = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_REAR    = 4'd2;
  localparam logic [OP_W-1:0] OP_ERASE       = 4'd3;
  localparam logic [OP_W-1:0] OP_ERASE_FRONT = 4'd4;
  localparam logic [OP_W-1:0] OP_ERASE_REAR  = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR       = 4'd6;
  localparam logic [OP_W-1:0] OP_READ_AT     = 4'd7;
  localparam logic [OP_W-1:0] OP_READ_FRONT  = 4'd8;
  localparam logic [OP_W-1:0] OP_READ_REAR   = 4'd9;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // One access to the element store: one write and one read per cycle.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // Physical slot of a logical index: (head + logical) mod CAPACITY.
  // The sum stays below twice the capacity, so one compare and subtract do.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] logical);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(logical);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* src/cas_store.sv */
module cas_store
  import cas_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/circular_array_sequence.sv */
// Each command is accepted in S_IDLE and ends in S_OUT, where its result loads the output register.
// Clear, rejected and unused commands go straight to S_OUT; a read or front erase passes S_GRAB,
// a rear insert S_PUT; an indexed insert or erase moves elements one by one in S_MOVE and S_DRAIN.
// No new command is taken until its result is loaded, and a result waits in S_OUT while out_tready
// holds back the one before it.
// Reset (rst_n low, synchronous): list empty, head at slot 0, no result pending.
module circular_array_sequence
  import cas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // opcode[3:0], position[7:4], data_word[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_word[31:0], status[33:32], element_count[38:34],
                                  // is_empty[39], is_full[40], zero[47:41]
);

`include "circular_array_sequence_macros.svh"

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GRAB  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ins_r, ins_nxt;
  logic              move_r, move_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]  src_r, src_nxt;
  logic [CNT_W-1:0]  stop_r, stop_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [WORD_W-1:0] res_word_r, res_word_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [ST_W-1:0]   out_st_r, out_st_nxt;
  logic [CNTF_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [OP_W-1:0]   op;
  logic [CNT_W-1:0]  pos_in;
  logic [WORD_W-1:0] word_in;
  logic [CNT_W-1:0]  last_idx;
  logic [CNT_W-1:0]  ins_pos;
  logic [CNT_W-1:0]  tgt;
  logic [CNT_W:0]    tgt_plus;
  logic [CNT_W-1:0]  dst;
  logic              accept;
  logic              out_load;
  mem_req_t          req;
  logic [WORD_W-1:0] rdata;

  cas_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Fields of the incoming transaction.
  assign op      = in_tdata[3:0];
  assign pos_in  = CNT_W'(in_tdata[7:4]);
  assign word_in = in_tdata[39:8];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Target indexes of the command.
  always_comb begin
    last_idx = (count_r == '0) ? '0 : count_r - CNT_W'(1);
    case (op)
      OP_INS_FRONT: ins_pos = '0;
      OP_INS_REAR:  ins_pos = count_r;
      default:      ins_pos = pos_in;
    endcase
    case (op)
      OP_ERASE_FRONT, OP_READ_FRONT: tgt = '0;
      OP_ERASE_REAR, OP_READ_REAR:   tgt = last_idx;
      default:                       tgt = pos_in;
    endcase
    tgt_plus = (CNT_W+1)'(tgt) + (CNT_W+1)'(1);
    dst      = ins_r ? src_r + CNT_W'(1) : src_r - CNT_W'(1);
  end

  // Sequencer and store accesses.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    ins_nxt       = ins_r;
    move_nxt      = move_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    src_nxt       = src_r;
    stop_nxt      = stop_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    res_word_nxt  = res_word_r;
    res_st_nxt    = res_st_r;
    req           = '0;

    case (state_r)
      S_IDLE: begin
        // The read of the target slot goes out at accept; it is harmless otherwise.
        req.re    = 1'b1;
        req.raddr = slot_of(head_r, tgt);
        if (accept) begin
          res_word_nxt = '0;
          res_st_nxt   = ST_OK;
          pos_nxt      = ins_pos;
          word_nxt     = word_in;
          pend_nxt     = 1'b0;
          move_nxt     = 1'b0;
          state_nxt    = S_OUT;
          if (op inside {OP_INSERT, OP_INS_FRONT, OP_INS_REAR}) begin
            ins_nxt = 1'b1;
            if (count_r >= CNT_W'(CAPACITY)) begin
              res_st_nxt = ST_FULL;
            end else if (ins_pos > count_r) begin
              res_st_nxt = ST_RANGE;
            end else begin
              count_nxt = count_r + CNT_W'(1);
              if (ins_pos == count_r) begin
                state_nxt = S_PUT;
              end else begin
                src_nxt   = count_r - CNT_W'(1);
                stop_nxt  = ins_pos;
                state_nxt = S_MOVE;
              end
            end
          end else if (op inside {OP_ERASE, OP_ERASE_FRONT, OP_ERASE_REAR,
                                  OP_READ_AT, OP_READ_FRONT, OP_READ_REAR}) begin
            ins_nxt = 1'b0;
            if (count_r == '0) begin
              res_st_nxt = ST_EMPTY;
            end else if (tgt >= count_r) begin
              res_st_nxt = ST_RANGE;
            end else begin
              state_nxt = S_GRAB;
              if (op inside {OP_ERASE, OP_ERASE_FRONT, OP_ERASE_REAR}) begin
                count_nxt = count_r - CNT_W'(1);
                if (tgt == '0) begin
                  // Front erase just advances the head.
                  head_nxt = slot_of(head_r, CNT_W'(1));
                end else if (tgt_plus < (CNT_W+1)'(count_r)) begin
                  move_nxt = 1'b1;
                  src_nxt  = tgt_plus[CNT_W-1:0];
                  stop_nxt = count_r - CNT_W'(1);
                end
              end
            end
          end else if (op == OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end

      S_GRAB: begin
        res_word_nxt = rdata;
        state_nxt    = move_r ? S_MOVE : S_OUT;
      end

      S_MOVE: begin
        // Read the next source while writing the one fetched last cycle.
        req.re        = 1'b1;
        req.raddr     = slot_of(head_r, src_r);
        req.we        = pend_r;
        req.waddr     = pend_slot_r;
        req.wdata     = rdata;
        pend_nxt      = 1'b1;
        pend_slot_nxt = slot_of(head_r, dst);
        if (src_r == stop_r) begin
          state_nxt = S_DRAIN;
        end else begin
          src_nxt = ins_r ? src_r - CNT_W'(1) : src_r + CNT_W'(1);
        end
      end

      S_DRAIN: begin
        req.we    = pend_r;
        req.waddr = pend_slot_r;
        req.wdata = rdata;
        pend_nxt  = 1'b0;
        state_nxt = ins_r ? S_PUT : S_OUT;
      end

      S_PUT: begin
        req.we    = 1'b1;
        req.waddr = slot_of(head_r, pos_r);
        req.wdata = word_r;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: holds a result until the downstream side takes it.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res_word_r;
      out_st_nxt    = res_st_r;
      out_cnt_nxt   = CNTF_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r       <= ins_nxt;
    move_r      <= move_nxt;
    pos_r       <= pos_nxt;
    word_r      <= word_nxt;
    src_r       <= src_nxt;
    stop_r      <= stop_nxt;
    pend_slot_r <= pend_slot_nxt;
    res_word_r  <= res_word_nxt;
    res_st_r    <= res_st_nxt;
    out_word_r  <= out_word_nxt;
    out_st_r    <= out_st_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // Pack the result transaction.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       (out_cnt_r == CNTF_W'(CAPACITY)),
                       (out_cnt_r == '0),
                       out_cnt_r,
                       out_st_r,
                       out_word_r};

  // Checks on the sequencer and the list bookkeeping.
  `CAS_ASSERT(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `CAS_ASSERT_NEXT(a_busy_after_accept, accept, !in_tready, "accepted while busy")
  `CAS_ASSERT(a_full_status, out_valid_r && (out_st_r == ST_FULL), out_tdata[40], "full flag low")

endmodule

/* tb/tb_circular_array_sequence.sv */
module tb_circular_array_sequence;
  import cas_pkg::*;

  // Opcodes that the block leaves undecoded.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  localparam int DIRECTED_ROWS = 25;
  localparam int TOTAL_ITEMS   = 550;
  localparam int DRAIN_CYCLES  = 30;

  typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind_t;

  // One expected response of the list.
  typedef struct packed {
    logic [WORD_W-1:0] rd;
    logic [ST_W-1:0]   st;
    logic [CNTF_W-1:0] cnt;
    logic              empty;
    logic              full;
  } list_result_t;

  // One row of the directed table; checked rows carry the response typed in.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] data;
    logic              checked;
    logic [WORD_W-1:0] rd;
    logic [ST_W-1:0]   st;
    logic [CNTF_W-1:0] cnt;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // opcode[3:0], position[7:4], data_word[39:8]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // read_word[31:0], status[33:32], element_count[38:34],
                                // is_empty[39], is_full[40], zero[47:41]

  // Shadow copy of the list held by the block.
  logic [WORD_W-1:0] shadow_words [CAPACITY];
  int                shadow_head;
  int                shadow_count;

  list_result_t pending_results [$];
  stim_row_t    directed_rows [DIRECTED_ROWS];
  int           mismatches = 0;
  int           burst_left;
  int           items_sent;
  int unsigned  rx_cycle = 0;

  circular_array_sequence i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Physical slot of a logical index in the shadow list.
  function automatic int slot_index(input int logical);
    return (shadow_head + logical) % CAPACITY;
  endfunction

  function automatic logic [ST_W-1:0] shadow_insert(input int pos,
                                                    input logic [WORD_W-1:0] word);
    int i;
    if (shadow_count >= CAPACITY) begin
      return ST_FULL;
    end
    if (pos > shadow_count) begin
      return ST_RANGE;
    end
    for (i = shadow_count; i > pos; i--) begin
      shadow_words[slot_index(i)] = shadow_words[slot_index(i - 1)];
    end
    shadow_words[slot_index(pos)] = word;
    shadow_count++;
    return ST_OK;
  endfunction

  function automatic logic [ST_W-1:0] shadow_remove(input int pos,
                                                    output logic [WORD_W-1:0] word);
    int i;
    word = '0;
    if (shadow_count == 0) begin
      return ST_EMPTY;
    end
    if (pos >= shadow_count) begin
      return ST_RANGE;
    end
    word = shadow_words[slot_index(pos)];
    // Removing the front only moves the head; anything else closes the gap.
    if (pos == 0) begin
      shadow_head = slot_index(1);
    end else begin
      for (i = pos; i + 1 < shadow_count; i++) begin
        shadow_words[slot_index(i)] = shadow_words[slot_index(i + 1)];
      end
    end
    shadow_count--;
    return ST_OK;
  endfunction

  function automatic logic [ST_W-1:0] shadow_peek(input int pos, output logic [WORD_W-1:0] word);
    word = '0;
    if (shadow_count == 0) begin
      return ST_EMPTY;
    end
    if (pos >= shadow_count) begin
      return ST_RANGE;
    end
    word = shadow_words[slot_index(pos)];
    return ST_OK;
  endfunction

  // Applies one command to the shadow list and returns the response it gives.
  function automatic list_result_t predict_command(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] data);
    list_result_t res;
    logic [WORD_W-1:0] word;
    logic [ST_W-1:0] st;
    int last;
    word = '0;
    st = ST_OK;
    last = (shadow_count == 0) ? 0 : shadow_count - 1;
    case (op)
      OP_INSERT:      st = shadow_insert(int'(pos), data);
      OP_INS_FRONT:   st = shadow_insert(0, data);
      OP_INS_REAR:    st = shadow_insert(shadow_count, data);
      OP_ERASE:       st = shadow_remove(int'(pos), word);
      OP_ERASE_FRONT: st = shadow_remove(0, word);
      OP_ERASE_REAR:  st = shadow_remove(last, word);
      OP_CLEAR:       shadow_count = 0;
      OP_READ_AT:     st = shadow_peek(int'(pos), word);
      OP_READ_FRONT:  st = shadow_peek(0, word);
      OP_READ_REAR:   st = shadow_peek(last, word);
      default: ;
    endcase
    res.rd = word;
    res.st = st;
    res.cnt = CNTF_W'(shadow_count);
    res.empty = (shadow_count == 0);
    res.full = (shadow_count == CAPACITY);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // Offers one command, waits for its transaction and records the response it owes.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] data, input logic typed,
                              input list_result_t typed_res);
    list_result_t pred;
    int gap;
    // Sender idles between bursts.
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {data, pos, op};
    do @(posedge clk); while (!in_tready);
    pred = predict_command(op, pos, data);
    pending_results.push_back(typed ? typed_res : pred);
    burst_left--;
    items_sent++;
  endtask

  // Receiver: check each result transaction, then pick the next ready level.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.rd) report_mismatch("read_word", out_tdata[31:0], want.rd);
        if (out_tdata[33:32] !== want.st) begin
          report_mismatch("status", WORD_W'(out_tdata[33:32]), WORD_W'(want.st));
        end
        if (out_tdata[38:34] !== want.cnt) begin
          report_mismatch("element_count", WORD_W'(out_tdata[38:34]), WORD_W'(want.cnt));
        end
        if (out_tdata[39] !== want.empty) begin
          report_mismatch("is_empty", WORD_W'(out_tdata[39]), WORD_W'(want.empty));
        end
        if (out_tdata[40] !== want.full) begin
          report_mismatch("is_full", WORD_W'(out_tdata[40]), WORD_W'(want.full));
        end
        if (out_tdata[47:41] !== '0) begin
          report_mismatch("padding", WORD_W'(out_tdata[47:41]), '0);
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 97) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_cycle % 4 == 0);
      default: out_tready <= (rx_cycle % 16 >= 10);
    endcase
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    list_result_t typed_res;
    stim_row_t row;
    phase_kind_t kind;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [WORD_W-1:0] data;
    int phase_len;
    int r;
    int ins_lim;
    int era_lim;

    for (int i = 0; i < CAPACITY; i++) shadow_words[i] = '0;
    shadow_head = 0;
    shadow_count = 0;
    burst_left = 0;
    items_sent = 0;

    // Starts empty, then builds and picks apart a short list with edge words.
    directed_rows = '{
      '{OP_READ_FRONT,  4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_ERASE_FRONT, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_READ_REAR,   4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_ERASE,       4'd15, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_INSERT,      4'd1,  32'h0000_0005, 1'b1, 32'h0000_0000, ST_RANGE, 5'd0},
      '{OP_INSERT,      4'd0,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,    5'd1},
      '{OP_INS_REAR,    4'd0,  32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
      '{OP_INS_FRONT,   4'd0,  32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK,    5'd3},
      '{OP_READ_AT,     4'd2,  32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OK,    5'd3},
      '{OP_READ_AT,     4'd3,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 5'd3},
      '{OP_INSERT,      4'd4,  32'h1234_5678, 1'b1, 32'h0000_0000, ST_RANGE, 5'd3},
      '{OP_INSERT,      4'd3,  32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_INSERT,      4'd1,  32'ha5a5_a5a5, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_ERASE,       4'd2,  32'hffff_ffff, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_READ_FRONT,  4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_READ_REAR,   4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_ERASE_FRONT, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_ERASE_REAR,  4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_ERASE,       4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_ERASE,       4'd15, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 5'd1},
      '{OP_SPARE_HI,    4'd15, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK,    5'd1},
      '{OP_SPARE_LO,    4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_CLEAR,       4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_READ_AT,     4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_INS_REAR,    4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    5'd0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      typed_res.rd = row.rd;
      typed_res.st = row.st;
      typed_res.cnt = row.cnt;
      typed_res.empty = (row.cnt == 0);
      typed_res.full = (row.cnt == CAPACITY);
      send_command(row.op, row.pos, row.data, row.checked, typed_res);
    end

    // Random phases lean toward filling, draining or churning the list.
    typed_res = '0;
    while (items_sent < TOTAL_ITEMS) begin
      kind = phase_kind_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 48);
      case (kind)
        PHASE_FILL:  begin ins_lim = 80; era_lim = 90; end
        PHASE_DRAIN: begin ins_lim = 20; era_lim = 85; end
        default:     begin ins_lim = 45; era_lim = 75; end
      endcase
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else if (kind == PHASE_MIXED && r < 5) begin
          op = OP_CLEAR;
        end else if (r < ins_lim) begin
          op = OP_W'($urandom_range(OP_INSERT, OP_INS_REAR));
        end else if (r < era_lim) begin
          op = OP_W'($urandom_range(OP_ERASE, OP_ERASE_REAR));
        end else begin
          op = OP_W'($urandom_range(OP_READ_AT, OP_READ_REAR));
        end

        // Mostly legal positions, sometimes anything the field holds.
        if ($urandom_range(0, 3) == 0) begin
          pos = POS_W'($urandom_range(0, 15));
        end else if (op == OP_INSERT) begin
          pos = POS_W'($urandom_range(0, (shadow_count > 15) ? 15 : shadow_count));
        end else begin
          pos = (shadow_count == 0) ? 4'd0 : POS_W'($urandom_range(0, shadow_count - 1));
        end

        case ($urandom_range(0, 19))
          0:       data = 32'h8000_0000;
          1:       data = 32'h7fff_ffff;
          2:       data = 32'hffff_ffff;
          3:       data = 32'h0000_0000;
          default: data = $urandom;
        endcase
        send_command(op, pos, data, 1'b0, typed_res);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_circular_array_sequence OK");
    end else begin
      $display("tb_circular_array_sequence NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("tb_circular_array_sequence NOT OK");
    $finish;
  end

endmodule
